[rtl/ctd_pkg.sv]
`default_nettype none
package ctd_pkg;

  localparam int unsigned EdgesPerCycle = 8;

  localparam int unsigned ToothW = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned RpmW   = 16;
  localparam int unsigned AngleW = 7;
  localparam int unsigned RevW   = 16;
  localparam int unsigned CamCntW = 8;
  localparam int unsigned CrankRpmW = 12;
  localparam int unsigned LevelW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [StampW-1:0]    StartWindow = StampW'(1500);
  localparam logic [RpmW-1:0]      LiteRpm     = RpmW'(1400);
  localparam logic [ToothW-1:0]    NoSyncTooth = ToothW'(99);
  localparam logic [CrankRpmW:0]   LockMargin  = (CrankRpmW + 1)'(30);
  localparam logic [ToothW-1:0]    SyncTooth   = ToothW'(6);
  localparam logic [ToothW-1:0]    WrapTooth   = ToothW'(EdgesPerCycle + 1);
  localparam logic [ToothW-1:0]    FirstTooth  = ToothW'(1);
  localparam logic [AngleW-1:0]    AngleStart  = AngleW'(90);
  localparam logic [AngleW-1:0]    AngleShort  = AngleW'(70);
  localparam logic [AngleW-1:0]    AngleLong   = AngleW'(110);
  localparam logic [CamCntW-1:0]   CamSyncCnt  = CamCntW'(2);
  localparam logic [RevW-1:0]      RevMax      = '1;

  localparam logic [LevelW-1:0]    LevelReset    = LevelW'(1);
  localparam logic [CrankRpmW-1:0] CrankRpmReset = CrankRpmW'(400);

  typedef enum logic [LevelW-1:0] {
    FILT_OFF        = 2'd0,
    FILT_LITE       = 2'd1,
    FILT_MEDIUM     = 2'd2,
    FILT_AGGRESSIVE = 2'd3
  } filt_level_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILTER_LEVEL = 2'd0,
    CFG_RESYNC_EN    = 2'd1,
    CFG_LOCK_EN      = 2'd2,
    CFG_CRANK_RPM    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_CRANK = 1'b0,
    OP_CAM   = 1'b1
  } op_e;

  typedef struct packed {
    logic              operation;
    logic [StampW-1:0] timestamp_us;
    logic [RpmW-1:0]   engine_rpm;
    logic              engine_cranking;
  } evt_t;

  typedef struct packed {
    logic              valid_trigger;
    logic [ToothW-1:0] tooth_number;
    logic              in_sync;
    logic [AngleW-1:0] tooth_angle;
    logic [StampW-1:0] filter_time_us;
    logic              new_revolution;
    logic              end_coil_1_3;
    logic              end_coil_2_4;
    logic [RevW-1:0]   revolution_count;
    logic [StampW-1:0] vvt_time_us;
  } res_t;

endpackage
`default_nettype wire

[rtl/ctd_intf.sv]
`default_nettype none
interface ctd_evt_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [ctd_pkg::StampW-1:0] timestamp_us;
  logic [ctd_pkg::RpmW-1:0]   engine_rpm;
  logic                       engine_cranking;

  modport source (output valid, operation, timestamp_us, engine_rpm, engine_cranking,
                  input ready);
  modport sink   (input valid, operation, timestamp_us, engine_rpm, engine_cranking,
                  output ready);
endinterface

interface ctd_res_if;
  logic                       valid;
  logic                       ready;
  logic                       valid_trigger;
  logic [ctd_pkg::ToothW-1:0] tooth_number;
  logic                       in_sync;
  logic [ctd_pkg::AngleW-1:0] tooth_angle;
  logic [ctd_pkg::StampW-1:0] filter_time_us;
  logic                       new_revolution;
  logic                       end_coil_1_3;
  logic                       end_coil_2_4;
  logic [ctd_pkg::RevW-1:0]   revolution_count;
  logic [ctd_pkg::StampW-1:0] vvt_time_us;

  modport source (output valid, valid_trigger, tooth_number, in_sync, tooth_angle,
                  filter_time_us, new_revolution, end_coil_1_3, end_coil_2_4,
                  revolution_count, vvt_time_us,
                  input ready);
  modport sink   (input valid, valid_trigger, tooth_number, in_sync, tooth_angle,
                  filter_time_us, new_revolution, end_coil_1_3, end_coil_2_4,
                  revolution_count, vvt_time_us,
                  output ready);
endinterface
`default_nettype wire

[rtl/ctd_in_stage.sv]
`default_nettype none
module ctd_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ctd_evt_if.sink            evt_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output ctd_pkg::evt_t      evt_o
);

  logic          valid_q, valid_d;
  ctd_pkg::evt_t evt_q;
  logic          load;

  // stage frees up in the same cycle its beat moves on
  assign evt_i.ready = !valid_q || take_i;
  assign load        = evt_i.valid && evt_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      evt_q.operation       <= evt_i.operation;
      evt_q.timestamp_us    <= evt_i.timestamp_us;
      evt_q.engine_rpm      <= evt_i.engine_rpm;
      evt_q.engine_cranking <= evt_i.engine_cranking;
    end
  end

  assign valid_o = valid_q;
  assign evt_o   = evt_q;

endmodule
`default_nettype wire

[rtl/ctd_core.sv]
`default_nettype none
module ctd_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ctd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [ctd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                            fire_i,
  input  wire ctd_pkg::evt_t                   evt_i,
  output ctd_pkg::res_t                        res_o
);

  // configuration
  ctd_pkg::filt_level_e              level_q;
  logic                              resync_en_q;
  logic                              lock_en_q;
  logic [ctd_pkg::CrankRpmW-1:0]     crank_rpm_q;

  // decoder state
  logic [ctd_pkg::ToothW-1:0]  tooth_q, tooth_d;
  logic                        sync_q, sync_d;
  logic [ctd_pkg::CamCntW-1:0] cam_cnt_q, cam_cnt_d;
  logic [ctd_pkg::StampW-1:0]  last_stamp_q, last_stamp_d;
  logic [ctd_pkg::RevW-1:0]    revs_q, revs_d;
  logic [ctd_pkg::StampW-1:0]  window_q, window_d;
  logic [ctd_pkg::AngleW-1:0]  angle_q, angle_d;
  logic [ctd_pkg::StampW-1:0]  cam_delay_q, cam_delay_d;

  logic [ctd_pkg::StampW-1:0]  gap;
  logic                        pass;
  logic [ctd_pkg::ToothW-1:0]  tooth_inc;
  logic [ctd_pkg::ToothW-1:0]  tooth_pass;
  logic                        odd;
  logic                        lite;
  logic [ctd_pkg::StampW-1:0]  gap_x3, gap_x5, gap_x9, gap_x11;
  logic [ctd_pkg::StampW-1:0]  win_calc;
  logic [ctd_pkg::CrankRpmW:0] lock_rpm;
  logic                        lock_on;
  logic                        valid_trig, new_rev, coil13, coil24;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= ctd_pkg::filt_level_e'(ctd_pkg::LevelReset);
      resync_en_q <= 1'b0;
      lock_en_q   <= 1'b0;
      crank_rpm_q <= ctd_pkg::CrankRpmReset;
    end else if (cfg_we_i) begin
      case (ctd_pkg::cfg_idx_e'(cfg_index_i))
        ctd_pkg::CFG_FILTER_LEVEL:
          level_q <= ctd_pkg::filt_level_e'(cfg_wdata_i[ctd_pkg::LevelW-1:0]);
        ctd_pkg::CFG_RESYNC_EN:    resync_en_q <= cfg_wdata_i[0];
        ctd_pkg::CFG_LOCK_EN:      lock_en_q   <= cfg_wdata_i[0];
        ctd_pkg::CFG_CRANK_RPM:    crank_rpm_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign gap       = evt_i.timestamp_us - last_stamp_q;
  assign pass      = (gap >= window_q) || (revs_q == '0);
  assign tooth_inc = tooth_q + ctd_pkg::ToothW'(1);

  // tooth count after a passing crank edge
  assign tooth_pass = (tooth_inc == ctd_pkg::WrapTooth) ? ctd_pkg::FirstTooth :
                      (((!sync_q || resync_en_q) && cam_cnt_q == ctd_pkg::CamSyncCnt) ?
                       ctd_pkg::SyncTooth : tooth_inc);

  // constant multiplies as shift-add, wrapping at 32 bits
  assign gap_x3  = (gap << 1) + gap;
  assign gap_x5  = (gap << 2) + gap;
  assign gap_x9  = (gap << 3) + gap;
  assign gap_x11 = (gap << 3) + (gap << 1) + gap;

  assign odd  = tooth_pass[0];
  assign lite = (level_q == ctd_pkg::FILT_LITE) || (evt_i.engine_rpm < ctd_pkg::LiteRpm);

  always_comb begin
    if (lite) begin
      win_calc = odd ? gap : (gap_x3 >> 3);
    end else begin
      case (level_q)
        ctd_pkg::FILT_MEDIUM:     win_calc = odd ? (gap_x5 >> 2) : (gap >> 1);
        ctd_pkg::FILT_AGGRESSIVE: win_calc = odd ? (gap_x11 >> 3) : (gap_x9 >> 5);
        default:                  win_calc = '0;
      endcase
    end
  end

  assign lock_rpm = {1'b0, crank_rpm_q} + ctd_pkg::LockMargin;
  assign lock_on  = lock_en_q && ({{(ctd_pkg::RpmW - ctd_pkg::CrankRpmW - 1){1'b0}}, lock_rpm}
                    > evt_i.engine_rpm);

  always_comb begin
    tooth_d      = tooth_q;
    sync_d       = sync_q;
    cam_cnt_d    = cam_cnt_q;
    last_stamp_d = last_stamp_q;
    revs_d       = revs_q;
    window_d     = window_q;
    angle_d      = angle_q;
    cam_delay_d  = cam_delay_q;
    valid_trig   = 1'b0;
    new_rev      = 1'b0;
    coil13       = 1'b0;
    coil24       = 1'b0;
    if (evt_i.operation == ctd_pkg::OP_CRANK) begin
      if (pass) begin
        valid_trig = 1'b1;
        tooth_d    = tooth_inc;
        if (tooth_inc == ctd_pkg::WrapTooth) begin
          tooth_d = ctd_pkg::FirstTooth;
          new_rev = 1'b1;
          if (revs_q != ctd_pkg::RevMax) begin
            revs_d = revs_q + ctd_pkg::RevW'(1);
          end
        end else if ((!sync_q || resync_en_q) && cam_cnt_q == ctd_pkg::CamSyncCnt) begin
          tooth_d = ctd_pkg::SyncTooth;
          sync_d  = 1'b1;
        end
        if (sync_d) begin
          angle_d  = odd ? ctd_pkg::AngleShort : ctd_pkg::AngleLong;
          window_d = win_calc;
        end
        last_stamp_d = evt_i.timestamp_us;
        if (lock_on) begin
          if (tooth_d == ctd_pkg::ToothW'(1) || tooth_d == ctd_pkg::ToothW'(5)) begin
            coil13 = 1'b1;
          end else if (tooth_d == ctd_pkg::ToothW'(3) || tooth_d == ctd_pkg::ToothW'(7)) begin
            coil24 = 1'b1;
          end
        end
        cam_cnt_d = '0;
      end
    end else begin
      if (evt_i.engine_cranking || !sync_q) begin
        window_d = ctd_pkg::StartWindow;
      end
      cam_cnt_d = cam_cnt_q + ctd_pkg::CamCntW'(1);
      if (tooth_q == ctd_pkg::FirstTooth && evt_i.timestamp_us > last_stamp_q) begin
        cam_delay_d = evt_i.timestamp_us - last_stamp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tooth_q      <= ctd_pkg::NoSyncTooth;
      sync_q       <= 1'b0;
      cam_cnt_q    <= '0;
      last_stamp_q <= '0;
      revs_q       <= '0;
      window_q     <= ctd_pkg::StartWindow;
      angle_q      <= ctd_pkg::AngleStart;
      cam_delay_q  <= '0;
    end else if (fire_i) begin
      tooth_q      <= tooth_d;
      sync_q       <= sync_d;
      cam_cnt_q    <= cam_cnt_d;
      last_stamp_q <= last_stamp_d;
      revs_q       <= revs_d;
      window_q     <= window_d;
      angle_q      <= angle_d;
      cam_delay_q  <= cam_delay_d;
    end
  end

  always_comb begin
    res_o.valid_trigger    = valid_trig;
    res_o.tooth_number     = tooth_d;
    res_o.in_sync          = sync_d;
    res_o.tooth_angle      = angle_d;
    res_o.filter_time_us   = window_d;
    res_o.new_revolution   = new_rev;
    res_o.end_coil_1_3     = coil13;
    res_o.end_coil_2_4     = coil24;
    res_o.revolution_count = revs_d;
    res_o.vvt_time_us      = cam_delay_d;
  end

endmodule
`default_nettype wire

[rtl/ctd_out_stage.sv]
`default_nettype none
module ctd_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire ctd_pkg::res_t res_i,
  output logic               take_o,
  ctd_res_if.source          res_o
);

  logic          valid_q, valid_d;
  ctd_pkg::res_t res_q;

  // result register is free when empty or when its beat leaves now
  assign take_o  = valid_i && (!valid_q || res_o.ready);
  assign valid_d = take_o || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid            = valid_q;
  assign res_o.valid_trigger    = res_q.valid_trigger;
  assign res_o.tooth_number     = res_q.tooth_number;
  assign res_o.in_sync          = res_q.in_sync;
  assign res_o.tooth_angle      = res_q.tooth_angle;
  assign res_o.filter_time_us   = res_q.filter_time_us;
  assign res_o.new_revolution   = res_q.new_revolution;
  assign res_o.end_coil_1_3     = res_q.end_coil_1_3;
  assign res_o.end_coil_2_4     = res_q.end_coil_2_4;
  assign res_o.revolution_count = res_q.revolution_count;
  assign res_o.vvt_time_us      = res_q.vvt_time_us;

endmodule
`default_nettype wire

[rtl/cam_crank_tooth_decoder_unit.sv]
// An accepted edge beat passes the input register, then is decoded into the
// result register that drives its result beat.
// Throughput: one edge per cycle unless results stall; the decoder state is
// updated once per edge, so the next edge sees it on the following cycle.
// Reset (rst_ni, async, active low): tooth 99, no sync, window 1500 us,
// angle 90, counters and stamps zero, registers at their defaults.
`default_nettype none
module cam_crank_tooth_decoder_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ctd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ctd_pkg::CfgDataW-1:0] cfg_wdata_i,
  ctd_evt_if.sink                           evt_i,
  ctd_res_if.source                         res_o
);

  logic          in_valid;
  ctd_pkg::evt_t in_evt;
  logic          take;
  ctd_pkg::res_t res;

  ctd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt_i),
    .take_i  (take),
    .valid_o (in_valid),
    .evt_o   (in_evt)
  );

  ctd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (take),
    .evt_i       (in_evt),
    .res_o       (res)
  );

  ctd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .res_i   (res),
    .take_o  (take),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned REPORT_MAX    = 50;

  // decoder constants, as the wheel is specified
  localparam logic [31:0] WINDOW_START = 32'd1500;
  localparam logic [31:0] LITE_BELOW   = 32'd1400;
  localparam logic [7:0]  TOOTH_NOSYNC = 8'd99;
  localparam logic [7:0]  TOOTH_SYNC   = 8'd6;
  localparam logic [7:0]  TOOTH_WRAP   = 8'(EdgesPerCycle + 1);
  localparam logic [6:0]  ANGLE_INIT   = 7'd90;
  localparam logic [6:0]  ANGLE_SHORT  = 7'd70;
  localparam logic [6:0]  ANGLE_LONG   = 7'd110;
  localparam logic [31:0] LOCK_MARGIN  = 32'd30;

  typedef struct {
    evt_t        ev;
    int unsigned gap;
  } edge_plan_t;

  typedef struct {
    logic [7:0]  tooth;
    logic        synced;
    logic [7:0]  cam_hits;
    logic [31:0] tooth_stamp;
    logic [15:0] revs;
    logic [31:0] window;
    logic [6:0]  angle;
    logic [31:0] cam_stamp;
    logic [31:0] vvt;
  } wheel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                send_valid = 1'b0;
  evt_t                send_evt   = '0;
  logic                take_ready = 1'b0;

  ctd_evt_if edge_bus ();
  ctd_res_if trig_bus ();

  assign edge_bus.valid           = send_valid;
  assign edge_bus.operation       = send_evt.operation;
  assign edge_bus.timestamp_us    = send_evt.timestamp_us;
  assign edge_bus.engine_rpm      = send_evt.engine_rpm;
  assign edge_bus.engine_cranking = send_evt.engine_cranking;
  assign trig_bus.ready           = take_ready;

  cam_crank_tooth_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (edge_bus),
    .res_o       (trig_bus)
  );

  always #5 clk_i = ~clk_i;

  // decoder shadow: configuration and wheel state
  filt_level_e         cfg_level     = FILT_LITE;
  logic                cfg_resync    = 1'b0;
  logic                cfg_lock      = 1'b0;
  logic [CrankRpmW-1:0] cfg_crank_rpm = CrankRpmW'(400);
  wheel_t wheel = '{tooth: TOOTH_NOSYNC, synced: 1'b0, cam_hits: '0, tooth_stamp: '0,
                    revs: '0, window: WINDOW_START, angle: ANGLE_INIT, cam_stamp: '0,
                    vvt: '0};

  edge_plan_t  edges_queued[$];
  res_t        triggers_due[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_wait   = 0;
  int unsigned sink_wait   = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_asks   = 0;
  int unsigned hold_done   = 0;
  bit          send_calm   = 1'b0;
  bit          sink_calm   = 1'b0;
  logic [31:0] t_now       = '0;

  // new filter window and gap angle from the measured gap, once in sync
  function automatic void retune_window(logic [31:0] gap, logic [15:0] rpm);
    logic        odd;
    logic [31:0] prod;
    odd = wheel.tooth[0];
    wheel.angle = odd ? ANGLE_SHORT : ANGLE_LONG;
    if (cfg_level == FILT_LITE || {16'd0, rpm} < LITE_BELOW) begin
      prod = gap * 32'd3;
      wheel.window = odd ? gap : prod >> 3;
    end else if (cfg_level == FILT_MEDIUM) begin
      prod = gap * 32'd5;
      wheel.window = odd ? prod >> 2 : gap >> 1;
    end else if (cfg_level == FILT_AGGRESSIVE) begin
      prod = odd ? gap * 32'd11 : gap * 32'd9;
      wheel.window = odd ? prod >> 3 : prod >> 5;
    end else begin
      wheel.window = '0;
    end
  endfunction

  function automatic res_t decode_edge(evt_t ev);
    res_t        r;
    logic [31:0] gap;
    r = '0;
    if (ev.operation == OP_CRANK) begin
      gap = ev.timestamp_us - wheel.tooth_stamp;
      if (gap >= wheel.window || wheel.revs == '0) begin
        r.valid_trigger = 1'b1;
        wheel.tooth = wheel.tooth + 8'd1;
        if (wheel.tooth == TOOTH_WRAP) begin
          wheel.tooth = 8'd1;
          r.new_revolution = 1'b1;
          if (wheel.revs != 16'hFFFF) wheel.revs = wheel.revs + 16'd1;
        end else if ((!wheel.synced || cfg_resync) && wheel.cam_hits == 8'd2) begin
          wheel.tooth  = TOOTH_SYNC;
          wheel.synced = 1'b1;
        end
        if (wheel.synced) retune_window(gap, ev.engine_rpm);
        wheel.tooth_stamp = ev.timestamp_us;
        if (cfg_lock && {16'd0, ev.engine_rpm} < 32'(cfg_crank_rpm) + LOCK_MARGIN) begin
          if (wheel.tooth == 8'd1 || wheel.tooth == 8'd5) r.end_coil_1_3 = 1'b1;
          else if (wheel.tooth == 8'd3 || wheel.tooth == 8'd7) r.end_coil_2_4 = 1'b1;
        end
        wheel.cam_hits = '0;
      end
    end else begin
      if (ev.engine_cranking || !wheel.synced) wheel.window = WINDOW_START;
      wheel.cam_stamp = ev.timestamp_us;
      wheel.cam_hits  = wheel.cam_hits + 8'd1;
      if (wheel.tooth == 8'd1 && ev.timestamp_us > wheel.tooth_stamp)
        wheel.vvt = ev.timestamp_us - wheel.tooth_stamp;
    end
    r.tooth_number     = wheel.tooth;
    r.in_sync          = wheel.synced;
    r.tooth_angle      = wheel.angle;
    r.filter_time_us   = wheel.window;
    r.revolution_count = wheel.revs;
    r.vvt_time_us      = wheel.vvt;
    return r;
  endfunction

  function automatic void field_diff(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
    end
  endfunction

  function automatic void check_trigger();
    res_t want;
    if (triggers_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t ns: result with none expected, actual tooth %0d", $time,
                 trig_bus.tooth_number);
      return;
    end
    want = triggers_due.pop_front();
    field_diff("valid_trigger", 32'(want.valid_trigger), 32'(trig_bus.valid_trigger));
    field_diff("tooth_number", 32'(want.tooth_number), 32'(trig_bus.tooth_number));
    field_diff("in_sync", 32'(want.in_sync), 32'(trig_bus.in_sync));
    field_diff("tooth_angle", 32'(want.tooth_angle), 32'(trig_bus.tooth_angle));
    field_diff("filter_time_us", want.filter_time_us, trig_bus.filter_time_us);
    field_diff("new_revolution", 32'(want.new_revolution), 32'(trig_bus.new_revolution));
    field_diff("end_coil_1_3", 32'(want.end_coil_1_3), 32'(trig_bus.end_coil_1_3));
    field_diff("end_coil_2_4", 32'(want.end_coil_2_4), 32'(trig_bus.end_coil_2_4));
    field_diff("revolution_count", 32'(want.revolution_count), 32'(trig_bus.revolution_count));
    field_diff("vvt_time_us", want.vvt_time_us, trig_bus.vvt_time_us);
  endfunction

  // edge driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_edges
    logic       free;
    edge_plan_t plan;
    if (!rst_ni) begin
      send_valid <= 1'b0;
      send_wait = 0;
    end else begin
      free = !send_valid;
      if (send_valid && edge_bus.ready) begin
        triggers_due.push_back(decode_edge(send_evt));
        free = 1'b1;
      end
      if (free) begin
        if (edges_queued.size() != 0 && send_wait >= edges_queued[0].gap) begin
          plan = edges_queued.pop_front();
          send_evt   <= plan.ev;
          send_valid <= 1'b1;
          send_wait = 0;
        end else begin
          send_valid <= 1'b0;
          if (edges_queued.size() != 0) send_wait++;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
    end else begin
      if (trig_bus.valid && take_ready) begin
        check_trigger();
        sink_wait = sink_calm ? 0 : $urandom_range(0, 15);
      end
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        take_ready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cam_crank_tooth_decoder_unit test failed");
      $finish;
    end
  end

  task automatic queue_edge(op_e op, logic [31:0] ts, logic [15:0] rpm, logic cranking);
    edge_plan_t plan;
    plan.ev.operation       = op;
    plan.ev.timestamp_us    = ts;
    plan.ev.engine_rpm      = rpm;
    plan.ev.engine_cranking = cranking;
    plan.gap = send_calm ? 0 : $urandom_range(0, 15);
    edges_queued.push_back(plan);
    t_now = ts;
  endtask

  task automatic push_edge(op_e op, int unsigned dt, logic [15:0] rpm, logic cranking);
    queue_edge(op, t_now + 32'(dt), rpm, cranking);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (edges_queued.size() != 0 || send_valid || triggers_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILTER_LEVEL: cfg_level     = filt_level_e'(val[LevelW-1:0]);
      CFG_RESYNC_EN:    cfg_resync    = val[0];
      CFG_LOCK_EN:      cfg_lock      = val[0];
      CFG_CRANK_RPM:    cfg_crank_rpm = val[CrankRpmW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(filt_level_e lvl, logic resync, logic lock,
                          logic [CrankRpmW-1:0] crpm);
    drain();
    write_reg(CFG_FILTER_LEVEL, CfgDataW'(lvl));
    write_reg(CFG_RESYNC_EN, CfgDataW'(resync));
    write_reg(CFG_LOCK_EN, CfgDataW'(lock));
    write_reg(CFG_CRANK_RPM, CfgDataW'(crpm));
    @(negedge clk_i);
  endtask

  // well-formed wheel: alternating short/long gaps, cam pair ahead of tooth 6,
  // with some chatter, misplaced cam counts and odd rpm values mixed in
  task automatic run_wheel(int unsigned revs, logic [15:0] rpm, logic cranking);
    int unsigned base;
    int unsigned gap;
    int unsigned cams;
    logic [15:0] r;
    logic        c;
    base = 15_000_000 / ((rpm < 100) ? 100 : int'(rpm));
    for (int unsigned n = 0; n < revs; n++) begin
      for (int k = 1; k <= EdgesPerCycle; k++) begin
        r = ($urandom_range(0, 15) == 0) ? 16'($urandom) : rpm;
        c = cranking ^ ($urandom_range(0, 15) == 0);
        if (k == 6) begin
          cams = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 2;
          repeat (cams) push_edge(OP_CAM, $urandom_range(1, base / 8 + 1), r, c);
        end
        if ($urandom_range(0, 9) == 0)
          push_edge(OP_CRANK, $urandom_range(1, base / 4 + 1), r, c);
        gap = ((k % 2 == 0) ? base * 70 : base * 110) / 90;
        gap = gap * $urandom_range(85, 140) / 100;
        push_edge(OP_CRANK, gap, r, c);
        if (k == 1 && $urandom_range(0, 1) == 1)
          push_edge(OP_CAM, $urandom_range(1, base / 2 + 1), r, c);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes and both edge kinds, all accepted while no revolution counted
    queue_edge(OP_CRANK, 32'h0000_0000, 16'h0000, 1'b0);
    queue_edge(OP_CRANK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    queue_edge(OP_CAM,   32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    queue_edge(OP_CRANK, 32'h0000_0000, 16'h5555, 1'b0);
    queue_edge(OP_CAM,   32'h0000_0000, 16'hAAAA, 1'b0);
    queue_edge(OP_CRANK, 32'h8000_0000, 16'd1399, 1'b1);
    queue_edge(OP_CAM,   32'h7FFF_FFFF, 16'd1400, 1'b0);
    queue_edge(OP_CRANK, 32'h7FFF_FFFF, 16'd429, 1'b1);

    // cold spin without a cam pair: count runs past 255 and wraps to tooth 1
    for (int i = 0; i < 176; i++) begin
      push_edge(OP_CRANK, $urandom_range(1600, 30000), 16'($urandom_range(0, 1500)), 1'b1);
      if ($urandom_range(0, 7) == 0)
        push_edge(OP_CAM, $urandom_range(1, 1000), 16'($urandom_range(0, 1500)), 1'b1);
    end

    set_regs(FILT_LITE, 1'b0, 1'b1, 12'd400);
    run_wheel(8, 16'd300, 1'b1);

    set_regs(FILT_MEDIUM, 1'b1, 1'b1, 12'd2550);
    run_wheel(8, 16'd2000, 1'b0);

    set_regs(FILT_AGGRESSIVE, 1'b0, 1'b0, 12'd0);
    send_calm = 1'b1;
    run_wheel(8, 16'd3000, 1'b0);
    send_calm = 1'b0;

    // receiver holds off while the sender keeps pushing back to back
    set_regs(FILT_OFF, 1'b1, 1'b1, 12'd1000);
    hold_asks++;
    send_calm = 1'b1;
    for (int i = 0; i < 40; i++)
      push_edge(($urandom_range(0, 4) == 0) ? OP_CAM : OP_CRANK, $urandom_range(1, 20000),
                16'($urandom), 1'($urandom));
    send_calm = 1'b0;
    run_wheel(7, 16'd900, 1'b1);

    // timestamps run near the top of the 32-bit range, short of the wrap
    set_regs(FILT_AGGRESSIVE, 1'b1, 1'b1, 12'd2550);
    t_now = 32'hFFF0_0000;
    run_wheel(8, 16'd6000, 1'b0);

    set_regs(FILT_MEDIUM, 1'b0, 1'b1, 12'd0);
    sink_calm = 1'b1;
    run_wheel(8, 16'd1200, 1'b0);
    sink_calm = 1'b0;

    set_regs(FILT_LITE, 1'b1, 1'b0, 12'd1500);
    run_wheel(8, 16'($urandom_range(100, 9000)), 1'($urandom));

    set_regs(FILT_OFF, 1'b0, 1'b1, 12'd2550);
    run_wheel(8, 16'hFFFF, 1'b0);

    drain();
    if (mismatches == 0) begin
      $display("cam_crank_tooth_decoder_unit test passed");
    end else begin
      $display("cam_crank_tooth_decoder_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[cam_crank_tooth_decoder_unit.f]
rtl/ctd_pkg.sv
rtl/ctd_intf.sv
rtl/ctd_in_stage.sv
rtl/ctd_core.sv
rtl/ctd_out_stage.sv
rtl/cam_crank_tooth_decoder_unit.sv
verif/tb.sv
